// ===== src/first_fit_range_allocator_macros.svh =====
// assertion helpers for the allocator datapath
`ifndef FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FFRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FFRA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFRA_ASSERT_IMP(lbl, ante, cons, msg)
`define FFRA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/ffra_pkg.sv =====
`timescale 1ns / 1ps
package ffra_pkg;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_NOT_OWNED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ZERO      = 3'd4;

    // register indexes
    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_LEN   = 2'd1;
    localparam logic [1:0] REG_ALIGN = 2'd2;

    // check points
    localparam logic [1:0] CHK_PRE   = 2'd0;
    localparam logic [1:0] CHK_SCAN1 = 2'd1;
    localparam logic [1:0] CHK_SCAN2 = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] request_bytes;
        logic [31:0] release_start;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_start;
        logic [31:0] granted_bytes;
    } res_t;

    // one table entry, half-open range
    typedef struct packed {
        logic [31:0] lo;
        logic [32:0] hi;
    } ent_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CHECK,
        OP_SCAN_RD,
        OP_SCAN_EV,
        OP_PLAN,
        OP_SH_RD,
        OP_SH_WR,
        OP_W1,
        OP_W2,
        OP_RST,
        OP_FINISH
    } op_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_DOWN,
        SH_UP
    } sh_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // controller to datapath
    typedef struct packed {
        op_t        op;
        logic [1:0] phase;
        logic       second;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       more;
        logic       hit;
        logic       fail;
        logic       sh_more;
    } sts_t;

endpackage

// ===== src/first_fit_range_allocator.sv =====
`timescale 1ns / 1ps
// channel    | handshake                  | payload
// -----------+----------------------------+-------------------------------
// command    | start, busy                | item (command, bytes, start)
// result     | done (one-cycle strobe)    | result (status, grant)
// config     | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// a command beat is taken when start is high and busy is low
// a command loads and checks, then scans up to twice, reading then evaluating
// entries visited, plans, shifts and writes each table; reset skips the scans
// single read port per table: a read state comes before each evaluate or write
// rst_n clears counts, configuration and the sequencer; tables stay unwritten
// the result beat shows in the first cycle with busy low and cannot be held off
module first_fit_range_allocator #(
    parameter int FREE_SLOTS = 16,
    parameter int USED_SLOTS = 16,
    parameter int ADDR_BITS  = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ffra_pkg::in_t   item,
    output logic            done,
    output ffra_pkg::res_t  result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import ffra_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer
    ffra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    // tables and arithmetic
    ffra_dp #(
        .FREE_SLOTS (FREE_SLOTS),
        .USED_SLOTS (USED_SLOTS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .item      (item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .done      (done)
    );

endmodule

// ===== src/ffra_ctrl.sv =====
`timescale 1ns / 1ps
module ffra_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ffra_pkg::sts_t  sts,
    output ffra_pkg::ctl_t  ctl
);
    import ffra_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_CHK0    = 13'b0000000000010,
        S_SCAN_RD = 13'b0000000000100,
        S_SCAN_EV = 13'b0000000001000,
        S_CHK1    = 13'b0000000010000,
        S_CHK2    = 13'b0000000100000,
        S_PLAN    = 13'b0000001000000,
        S_SH_RD   = 13'b0000010000000,
        S_SH_WR   = 13'b0000100000000,
        S_W1      = 13'b0001000000000,
        S_W2      = 13'b0010000000000,
        S_RST     = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;
    state_t scan_end_state;
    logic   scan_end_second;

    // where a finished scan goes
    always_comb
    begin
        scan_end_state  = S_CHK1;
        scan_end_second = second_reg;
        if (second_reg)
        begin
            scan_end_second = 1'b0;
            scan_end_state  = (sts.cmd == CMD_ALLOC) ? S_PLAN : S_CHK2;
        end
    end

    // next state and command
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        ctl.op      = OP_NONE;
        ctl.phase   = CHK_PRE;
        ctl.second  = second_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op      = OP_LOAD;
                    second_next = 1'b0;
                    state_next  = S_CHK0;
                end
            end
            S_CHK0:
            begin
                ctl.op = OP_CHECK;
                if (sts.fail)
                    state_next = S_DONE;
                else if (sts.cmd == CMD_RESET)
                    state_next = S_RST;
                else if (sts.cmd == CMD_ALLOC || sts.cmd == CMD_FREE)
                    state_next = S_SCAN_RD;
                else
                    state_next = S_DONE;
            end
            S_SCAN_RD:
            begin
                ctl.op = OP_SCAN_RD;
                if (sts.more)
                    state_next = S_SCAN_EV;
                else
                begin
                    state_next  = scan_end_state;
                    second_next = scan_end_second;
                end
            end
            S_SCAN_EV:
            begin
                ctl.op = OP_SCAN_EV;
                if (sts.hit)
                begin
                    state_next  = scan_end_state;
                    second_next = scan_end_second;
                end
                else
                    state_next = S_SCAN_RD;
            end
            S_CHK1:
            begin
                ctl.op    = OP_CHECK;
                ctl.phase = CHK_SCAN1;
                if (sts.fail)
                    state_next = S_DONE;
                else
                begin
                    second_next = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_CHK2:
            begin
                ctl.op    = OP_CHECK;
                ctl.phase = CHK_SCAN2;
                state_next = sts.fail ? S_DONE : S_PLAN;
            end
            S_PLAN:
            begin
                ctl.op     = OP_PLAN;
                state_next = S_SH_RD;
            end
            S_SH_RD:
            begin
                ctl.op     = OP_SH_RD;
                state_next = sts.sh_more ? S_SH_WR : S_W1;
            end
            S_SH_WR:
            begin
                ctl.op     = OP_SH_WR;
                state_next = S_SH_RD;
            end
            S_W1:
            begin
                ctl.op     = OP_W1;
                state_next = S_W2;
            end
            S_W2:
            begin
                ctl.op = OP_W2;
                if (!second_reg)
                begin
                    second_next = 1'b1;
                    state_next  = S_PLAN;
                end
                else
                    state_next = S_DONE;
            end
            S_RST:
            begin
                ctl.op     = OP_RST;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                ctl.op     = OP_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== src/ffra_dp.sv =====
`timescale 1ns / 1ps
`include "first_fit_range_allocator_macros.svh"
module ffra_dp #(
    parameter int FREE_SLOTS = 16,
    parameter int USED_SLOTS = 16,
    parameter int ADDR_BITS  = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ffra_pkg::ctl_t  ctl,
    output ffra_pkg::sts_t  sts,
    input  ffra_pkg::in_t   item,
    input  logic            cfg_valid,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    output ffra_pkg::res_t  result,
    output logic            done
);
    import ffra_pkg::*;

    localparam int FAW      = $clog2(FREE_SLOTS);
    localparam int UAW      = $clog2(USED_SLOTS);
    localparam int FCW      = $clog2(FREE_SLOTS + 1);
    localparam int UCW      = $clog2(USED_SLOTS + 1);
    localparam int KW       = (FCW > UCW) ? FCW : UCW;
    localparam int LIM_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
    localparam logic [33:0] LIMIT = 34'd1 << LIM_BITS;

    // configuration
    logic [31:0] base_reg, len_reg;
    logic [3:0]  algn_reg;

    // latched command and scan state
    logic [1:0]    cmd_reg;
    logic [31:0]   req_reg, rs_reg;
    logic [33:0]   size_reg;
    logic [KW-1:0] cur_reg, h_idx_reg, p_reg;
    logic          found_reg;
    logic [31:0]   hs_reg;
    logic [32:0]   he_reg;
    logic [33:0]   b_reg, bend_reg;
    logic          prev_v_reg, nx_v_reg;
    logic [31:0]   prev_s_reg, nx_s_reg;
    logic [32:0]   prev_e_reg, nx_e_reg;
    logic [FCW-1:0] fc_reg;
    logic [UCW-1:0] uc_reg;
    logic [2:0]    st_reg;

    // edit plan
    sh_t           ed_sh_reg;
    cnt_op_t       ed_cnt_reg;
    logic [KW-1:0] ed_idx_reg, w1_idx_reg, w2_idx_reg;
    logic          w1_en_reg, w2_en_reg;
    ent_t          w1_d_reg, w2_d_reg;

    res_t res_reg;
    logic done_reg;

    // tables
    ent_t fmem [FREE_SLOTS];
    ent_t umem [USED_SLOTS];
    ent_t f_rd, u_rd, rd;

    logic          tbl_free;
    logic [KW-1:0] cnt_sel;
    logic [33:0]   a_m1, size_w, e_w, sum_w, rend;
    logic          nonempty;
    logic [33:0]   bcand, bcand_end;
    logic          hit_w;
    logic          bs_a, be_a, bs_r, be_r, left, right, fc_full, uc_full;
    logic [2:0]    v_pre, v_s1, v_s2, verdict;
    logic          sh_more;
    logic          re;
    logic [KW-1:0] ra;
    logic          we, f_we, u_we;
    logic [KW-1:0] wa;
    ent_t          wd;
    logic [KW-1:0] pm1;

    sh_t           pl_sh;
    cnt_op_t       pl_cnt;
    logic [KW-1:0] pl_idx, pl_w1idx, pl_w2idx, pl_cur;
    logic          pl_w1en, pl_w2en;
    ent_t          pl_w1d, pl_w2d;

    // shared arithmetic
    assign tbl_free = (cmd_reg == CMD_ALLOC) ^ ctl.second;
    assign cnt_sel  = tbl_free ? KW'(fc_reg) : KW'(uc_reg);
    assign a_m1     = (34'd1 << algn_reg) - 34'd1;
    assign size_w   = ({2'b00, req_reg} + a_m1) & ~a_m1;
    assign e_w      = {2'b00, rs_reg} + {2'b00, req_reg};
    assign sum_w    = {2'b00, base_reg} + {2'b00, len_reg};
    assign rend     = (sum_w < LIMIT) ? sum_w : LIMIT;
    assign nonempty = rend > {2'b00, base_reg};
    assign rd       = tbl_free ? f_rd : u_rd;
    assign fc_full  = (fc_reg == FCW'(FREE_SLOTS));
    assign uc_full  = (uc_reg == UCW'(USED_SLOTS));

    // entry evaluation during a scan
    assign bcand     = ({2'b00, rd.lo} + a_m1) & ~a_m1;
    assign bcand_end = bcand + size_reg;
    always_comb
    begin
        if (cmd_reg == CMD_ALLOC)
            hit_w = ctl.second ? ({2'b00, rd.lo} > b_reg)
                               : (bcand_end <= {1'b0, rd.hi});
        else
            hit_w = ctl.second ? (rd.lo > rs_reg)
                               : (rd.lo <= rs_reg && e_w <= {1'b0, rd.hi});
    end

    // status checks
    assign bs_a  = (b_reg == {2'b00, hs_reg});
    assign be_a  = (bend_reg == {1'b0, he_reg});
    assign bs_r  = (rs_reg == hs_reg);
    assign be_r  = (e_w == {1'b0, he_reg});
    assign left  = prev_v_reg && (prev_e_reg == {1'b0, rs_reg});
    assign right = nx_v_reg && ({2'b00, nx_s_reg} == e_w);

    always_comb
    begin
        v_pre = ST_OK;
        v_s1  = ST_OK;
        v_s2  = ST_OK;
        if (cmd_reg == CMD_ALLOC)
        begin
            if (req_reg == '0)
                v_pre = ST_ZERO;
            if (!found_reg)
                v_s1 = ST_NO_FIT;
            else if (uc_full)
                v_s1 = ST_FULL;
            else if (!bs_a && !be_a && fc_full)
                v_s1 = ST_FULL;
        end
        else if (cmd_reg == CMD_FREE)
        begin
            if (req_reg == '0)
                v_pre = ST_ZERO;
            else if (rs_reg < base_reg || e_w > rend)
                v_pre = ST_NOT_OWNED;
            if (!found_reg)
                v_s1 = ST_NOT_OWNED;
            if (!bs_r && !be_r && uc_full)
                v_s2 = ST_FULL;
            else if (!left && !right && fc_full)
                v_s2 = ST_FULL;
        end
        if (ctl.phase == CHK_PRE)
            verdict = v_pre;
        else if (ctl.phase == CHK_SCAN1)
            verdict = v_s1;
        else
            verdict = v_s2;
    end

    // edit plan for the table being changed
    assign pm1 = p_reg - KW'(1);
    always_comb
    begin
        pl_sh    = SH_NONE;
        pl_cnt   = CNT_KEEP;
        pl_idx   = h_idx_reg;
        pl_w1en  = 1'b0;
        pl_w1idx = h_idx_reg;
        pl_w1d   = ent_t'{lo: hs_reg, hi: he_reg};
        pl_w2en  = 1'b0;
        pl_w2idx = h_idx_reg;
        pl_w2d   = ent_t'{lo: hs_reg, hi: he_reg};
        if (cmd_reg == CMD_ALLOC && !ctl.second)
        begin
            if (bs_a && be_a)
            begin
                pl_sh  = SH_DOWN;
                pl_cnt = CNT_DEC;
            end
            else if (bs_a)
            begin
                pl_w1en = 1'b1;
                pl_w1d  = ent_t'{lo: bend_reg[31:0], hi: he_reg};
            end
            else if (be_a)
            begin
                pl_w1en = 1'b1;
                pl_w1d  = ent_t'{lo: hs_reg, hi: b_reg[32:0]};
            end
            else
            begin
                pl_sh    = SH_UP;
                pl_cnt   = CNT_INC;
                pl_idx   = h_idx_reg + KW'(1);
                pl_w1en  = 1'b1;
                pl_w1idx = h_idx_reg + KW'(1);
                pl_w1d   = ent_t'{lo: bend_reg[31:0], hi: he_reg};
                pl_w2en  = 1'b1;
                pl_w2d   = ent_t'{lo: hs_reg, hi: b_reg[32:0]};
            end
        end
        else if (cmd_reg == CMD_ALLOC)
        begin
            pl_sh    = SH_UP;
            pl_cnt   = CNT_INC;
            pl_idx   = p_reg;
            pl_w1en  = 1'b1;
            pl_w1idx = p_reg;
            pl_w1d   = ent_t'{lo: b_reg[31:0], hi: bend_reg[32:0]};
        end
        else if (!ctl.second)
        begin
            if (bs_r && be_r)
            begin
                pl_sh  = SH_DOWN;
                pl_cnt = CNT_DEC;
            end
            else if (bs_r)
            begin
                pl_w1en = 1'b1;
                pl_w1d  = ent_t'{lo: e_w[31:0], hi: he_reg};
            end
            else if (be_r)
            begin
                pl_w1en = 1'b1;
                pl_w1d  = ent_t'{lo: hs_reg, hi: {1'b0, rs_reg}};
            end
            else
            begin
                pl_sh    = SH_UP;
                pl_cnt   = CNT_INC;
                pl_idx   = h_idx_reg + KW'(1);
                pl_w1en  = 1'b1;
                pl_w1idx = h_idx_reg + KW'(1);
                pl_w1d   = ent_t'{lo: e_w[31:0], hi: he_reg};
                pl_w2en  = 1'b1;
                pl_w2d   = ent_t'{lo: hs_reg, hi: {1'b0, rs_reg}};
            end
        end
        else
        begin
            pl_w1en = 1'b1;
            if (left && right)
            begin
                pl_sh    = SH_DOWN;
                pl_cnt   = CNT_DEC;
                pl_idx   = p_reg;
                pl_w1idx = pm1;
                pl_w1d   = ent_t'{lo: prev_s_reg, hi: nx_e_reg};
            end
            else if (left)
            begin
                pl_w1idx = pm1;
                pl_w1d   = ent_t'{lo: prev_s_reg, hi: e_w[32:0]};
            end
            else if (right)
            begin
                pl_w1idx = p_reg;
                pl_w1d   = ent_t'{lo: rs_reg, hi: nx_e_reg};
            end
            else
            begin
                pl_sh    = SH_UP;
                pl_cnt   = CNT_INC;
                pl_idx   = p_reg;
                pl_w1idx = p_reg;
                pl_w1d   = ent_t'{lo: rs_reg, hi: e_w[32:0]};
            end
        end
        pl_cur = (pl_sh == SH_UP) ? cnt_sel : pl_idx;
    end

    // shift loop control
    always_comb
    begin
        case (ed_sh_reg)
            SH_DOWN: sh_more = ({1'b0, cur_reg} + (KW+1)'(1)) < {1'b0, cnt_sel};
            SH_UP:   sh_more = cur_reg > ed_idx_reg;
            default: sh_more = 1'b0;
        endcase
    end

    // read and write ports
    always_comb
    begin
        re = 1'b0;
        ra = cur_reg;
        we = 1'b0;
        wa = cur_reg;
        wd = rd;
        case (ctl.op)
            OP_SCAN_RD:
            begin
                re = 1'b1;
            end
            OP_SH_RD:
            begin
                re = 1'b1;
                ra = (ed_sh_reg == SH_DOWN) ? cur_reg + KW'(1) : cur_reg - KW'(1);
            end
            OP_SH_WR:
            begin
                we = 1'b1;
            end
            OP_W1:
            begin
                we = w1_en_reg;
                wa = w1_idx_reg;
                wd = w1_d_reg;
            end
            OP_W2:
            begin
                we = w2_en_reg;
                wa = w2_idx_reg;
                wd = w2_d_reg;
            end
            OP_RST:
            begin
                we = nonempty;
                wa = '0;
                wd = ent_t'{lo: base_reg, hi: rend[32:0]};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign f_we = we && ((ctl.op == OP_RST) || tbl_free);
    assign u_we = we && (ctl.op != OP_RST) && !tbl_free;

    // free table memory
    always_ff @(posedge clk)
    begin
        if (f_we)
            fmem[wa[FAW-1:0]] <= wd;
        if (re && tbl_free)
            f_rd <= fmem[ra[FAW-1:0]];
    end

    // used table memory
    always_ff @(posedge clk)
    begin
        if (u_we)
            umem[wa[UAW-1:0]] <= wd;
        if (re && !tbl_free)
            u_rd <= umem[ra[UAW-1:0]];
    end

    // control registers: configuration, counts, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            len_reg  <= '0;
            algn_reg <= '0;
            fc_reg   <= '0;
            uc_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_BASE)
                    base_reg <= cfg_data;
                else if (cfg_index == REG_LEN)
                    len_reg <= cfg_data;
                else if (cfg_index == REG_ALIGN)
                    algn_reg <= cfg_data[3:0];
            end
            if (ctl.op == OP_RST)
            begin
                uc_reg <= '0;
                fc_reg <= nonempty ? FCW'(1) : '0;
            end
            else if (ctl.op == OP_W2 && ed_cnt_reg == CNT_INC)
            begin
                if (tbl_free)
                    fc_reg <= fc_reg + FCW'(1);
                else
                    uc_reg <= uc_reg + UCW'(1);
            end
            else if (ctl.op == OP_W2 && ed_cnt_reg == CNT_DEC)
            begin
                if (tbl_free)
                    fc_reg <= fc_reg - FCW'(1);
                else
                    uc_reg <= uc_reg - UCW'(1);
            end
            done_reg <= (ctl.op == OP_FINISH);
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            OP_LOAD:
            begin
                cmd_reg <= item.command;
                req_reg <= item.request_bytes;
                rs_reg  <= item.release_start;
                st_reg  <= ST_OK;
            end
            OP_CHECK:
            begin
                st_reg  <= verdict;
                cur_reg <= '0;
                if (ctl.phase == CHK_PRE)
                begin
                    found_reg <= 1'b0;
                    size_reg  <= size_w;
                end
                if (ctl.phase != CHK_SCAN2)
                begin
                    prev_v_reg <= 1'b0;
                    nx_v_reg   <= 1'b0;
                end
            end
            OP_SCAN_RD:
            begin
                p_reg <= cur_reg;
            end
            OP_SCAN_EV:
            begin
                p_reg <= cur_reg;
                if (hit_w)
                begin
                    if (!ctl.second)
                    begin
                        found_reg <= 1'b1;
                        h_idx_reg <= cur_reg;
                        hs_reg    <= rd.lo;
                        he_reg    <= rd.hi;
                        b_reg     <= bcand;
                        bend_reg  <= bcand_end;
                    end
                    else
                    begin
                        nx_v_reg <= 1'b1;
                        nx_s_reg <= rd.lo;
                        nx_e_reg <= rd.hi;
                    end
                end
                else
                begin
                    cur_reg    <= cur_reg + KW'(1);
                    prev_v_reg <= 1'b1;
                    prev_s_reg <= rd.lo;
                    prev_e_reg <= rd.hi;
                end
            end
            OP_PLAN:
            begin
                ed_sh_reg  <= pl_sh;
                ed_cnt_reg <= pl_cnt;
                ed_idx_reg <= pl_idx;
                w1_en_reg  <= pl_w1en;
                w1_idx_reg <= pl_w1idx;
                w1_d_reg   <= pl_w1d;
                w2_en_reg  <= pl_w2en;
                w2_idx_reg <= pl_w2idx;
                w2_d_reg   <= pl_w2d;
                cur_reg    <= pl_cur;
            end
            OP_SH_WR:
            begin
                cur_reg <= (ed_sh_reg == SH_DOWN) ? cur_reg + KW'(1) : cur_reg - KW'(1);
            end
            OP_FINISH:
            begin
                res_reg.status <= st_reg;
                if (cmd_reg == CMD_ALLOC && st_reg == ST_OK)
                begin
                    res_reg.granted_start <= b_reg[31:0];
                    res_reg.granted_bytes <= size_reg[31:0];
                end
                else
                begin
                    res_reg.granted_start <= '0;
                    res_reg.granted_bytes <= '0;
                end
            end
            default:
            begin
                st_reg <= st_reg;
            end
        endcase
    end

    assign sts.cmd     = cmd_reg;
    assign sts.more    = cur_reg < cnt_sel;
    assign sts.hit     = hit_w;
    assign sts.fail    = (verdict != ST_OK);
    assign sts.sh_more = sh_more;

    assign result = res_reg;
    assign done   = done_reg;

    // table counts stay within their slots, result beat lasts one cycle
    `FFRA_ASSERT_IMP(a_fc_cap, 1'b1, fc_reg <= FCW'(FREE_SLOTS), "free count over capacity")
    `FFRA_ASSERT_IMP(a_uc_cap, 1'b1, uc_reg <= UCW'(USED_SLOTS), "used count over capacity")
    `FFRA_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "result strobe held two cycles")

endmodule
